// File: sv/bucketed_sorted_digest_match_assert.svh
// assertion macros for the bucketed sorted digest matcher
// used by the top level; expects signals clock and reset in scope
`ifndef BUCKETED_SORTED_DIGEST_MATCH_ASSERT_SVH
`define BUCKETED_SORTED_DIGEST_MATCH_ASSERT_SVH

// same-cycle implication
`define BSDM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSDM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bsdm_pkg.sv
// types, constants and helper functions for the bucketed sorted digest matcher
// used by bucketed_sorted_digest_match and the testbench; no dependencies
package bsdm_pkg;

   localparam int MAX_TARGETS      = 4096;
   localparam int MAX_DIGEST_BYTES = 32;
   localparam int WORDS            = (MAX_DIGEST_BYTES + 7) / 8;
   localparam int QWORDS           = 4;
   localparam int IDX_W            = $clog2(MAX_TARGETS);
   localparam int WORD_W           = $clog2(WORDS);
   localparam int TGT_DEPTH        = MAX_TARGETS * WORDS;
   localparam int TGT_AW           = $clog2(TGT_DEPTH);
   localparam int BKT_DEPTH        = 256;
   localparam int BKT_W            = 25;

   typedef enum logic [1:0] {
      CMD_TARGET = 2'd0,
      CMD_BUCKET = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUCKET,
      ST_RANGE,
      ST_PROBE,
      ST_CMP
   } state_type;

   typedef struct packed {
      cmd_type      command;
      logic [11:0]  entry_index;
      logic [1:0]   word_index;
      logic [63:0]  word_value;
      logic [7:0]   bucket_id;
      logic [11:0]  bucket_base;
      logic [12:0]  bucket_size;
      logic [3:0]   lane_tag;
      logic         last_word;
   } req_type;

   typedef struct packed {
      logic         found;
      logic [11:0]  target_index;
      logic [3:0]   lane_tag_out;
      logic [31:0]  match_total;
   } rsp_type;

   // keeps the bytes of word w that lie below digest length n
   function automatic logic [63:0] word_mask(input logic [1:0] w, input logic [5:0] n);
      logic [63:0] m;
      logic [5:0]  b;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         b = {1'b0, w, 3'(k)};
         if (b < n) m[63 - 8*k -: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage

// File: sv/bsdm_ram.sv
// generic single-port synchronous ram with registered read data
// no dependencies
module bsdm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/bucketed_sorted_digest_match.sv
// top level of the bucketed sorted digest matcher: command decode and search sequencer
// depends on bsdm_pkg, bsdm_ram and bucketed_sorted_digest_match_assert.svh
//
// A request is taken when start is high and busy is low. Target and bucket writes and query
// words without the last mark do not raise busy; the last query word starts a binary search
// and keeps busy high until it ends, with up to 13 probes for a 4096-entry bucket and 1 to 4
// digest words compared per probe (fewer when a word already differs). The target ram has a
// single port: one probe issues its address, then each compared word is read in turn.
// The result appears on rsp_data for exactly one cycle with rsp_strobe, in the same cycle
// that busy falls; the receiver cannot stall it, so it must capture every strobe. The target
// store is not cleared after reset and must be loaded before it is searched; the bucket table
// reads as empty until written.
`include "bucketed_sorted_digest_match_assert.svh"

module bucketed_sorted_digest_match (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bsdm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bsdm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata
);

   bsdm_pkg::state_type state_ff, state_in;
   logic [63:0]  query_ff [bsdm_pkg::QWORDS];
   logic [63:0]  query_in [bsdm_pkg::QWORDS];
   logic [3:0]   lane_ff, lane_in;
   logic [bsdm_pkg::IDX_W-1:0] base_ff, base_in;
   logic [bsdm_pkg::IDX_W:0]   lo_ff, lo_in;
   logic [bsdm_pkg::IDX_W-1:0] hi_ff, hi_in;
   logic [bsdm_pkg::IDX_W-1:0] mid_ff, mid_in;
   logic [1:0]   wcnt_ff, wcnt_in;
   logic [bsdm_pkg::BKT_DEPTH-1:0] bvalid_ff, bvalid_in;
   logic         bvalid_rd_ff;
   logic [31:0]  cnt_ff, cnt_in;
   logic [5:0]   digest_bytes_ff;
   logic         rsp_strobe_ff, rsp_strobe_in;
   bsdm_pkg::rsp_type rsp_ff, rsp_in;

   logic         accept;
   logic [5:0]   n_eff;
   logic [1:0]   last_w;
   logic [63:0]  mask;
   logic [63:0]  s_word;
   logic [63:0]  q_word;
   logic [bsdm_pkg::IDX_W-1:0] bbase;
   logic [12:0]  bsize;
   logic [bsdm_pkg::IDX_W+1:0] lim;
   logic [bsdm_pkg::IDX_W+1:0] size_eff;
   logic [bsdm_pkg::IDX_W+1:0] mid_sum;
   logic [bsdm_pkg::IDX_W-1:0] probe_idx;

   logic                       tgt_we;
   logic [bsdm_pkg::TGT_AW-1:0] tgt_addr;
   logic [63:0]                tgt_rdata;
   logic                       bkt_we;
   logic [7:0]                 bkt_addr;
   logic [bsdm_pkg::BKT_W-1:0] bkt_rdata;

   bsdm_ram #(.WIDTH(64), .DEPTH(bsdm_pkg::TGT_DEPTH)) u_target_ram (
      .clock (clock),
      .we    (tgt_we),
      .addr  (tgt_addr),
      .wdata (req_data.word_value),
      .rdata (tgt_rdata)
   );

   bsdm_ram #(.WIDTH(bsdm_pkg::BKT_W), .DEPTH(bsdm_pkg::BKT_DEPTH)) u_bucket_ram (
      .clock (clock),
      .we    (bkt_we),
      .addr  (bkt_addr),
      .wdata ({req_data.bucket_size, req_data.bucket_base}),
      .rdata (bkt_rdata)
   );

   assign busy   = (state_ff != bsdm_pkg::ST_IDLE);
   assign accept = start && !busy;

   // effective digest length and last word to compare
   always_comb begin
      if (digest_bytes_ff == 6'd0) begin
         n_eff = 6'd1;
      end else if (digest_bytes_ff > 6'(bsdm_pkg::MAX_DIGEST_BYTES)) begin
         n_eff = 6'(bsdm_pkg::MAX_DIGEST_BYTES);
      end else begin
         n_eff = digest_bytes_ff;
      end
   end

   assign last_w    = 2'((n_eff - 6'd1) >> 3);
   assign mask      = bsdm_pkg::word_mask(wcnt_ff, n_eff);
   assign s_word    = tgt_rdata & mask;
   assign q_word    = query_ff[wcnt_ff] & mask;
   assign probe_idx = base_ff + mid_ff;

   assign bbase    = bvalid_rd_ff ? bkt_rdata[bsdm_pkg::IDX_W-1:0] : '0;
   assign bsize    = bvalid_rd_ff ? bkt_rdata[24:12] : '0;
   assign lim      = (bsdm_pkg::IDX_W+2)'(bsdm_pkg::MAX_TARGETS) - (bsdm_pkg::IDX_W+2)'(bbase);
   assign size_eff = ((bsdm_pkg::IDX_W+2)'(bsize) > lim) ? lim : (bsdm_pkg::IDX_W+2)'(bsize);
   assign mid_sum  = (bsdm_pkg::IDX_W+2)'(lo_ff) + (bsdm_pkg::IDX_W+2)'(hi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bsdm_pkg::ST_IDLE;
         bvalid_ff       <= '0;
         cnt_ff          <= '0;
         digest_bytes_ff <= 6'd32;
         rsp_strobe_ff   <= 1'b0;
         for (int i = 0; i < bsdm_pkg::QWORDS; i++) query_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         bvalid_ff     <= bvalid_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         for (int i = 0; i < bsdm_pkg::QWORDS; i++) query_ff[i] <= query_in[i];
         if (csr_we) begin
            digest_bytes_ff <= csr_wdata;
         end
      end
      lane_ff      <= lane_in;
      base_ff      <= base_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      wcnt_ff      <= wcnt_in;
      rsp_ff       <= rsp_in;
      bvalid_rd_ff <= bvalid_ff[bkt_addr];
   end

   always_comb begin
      state_in      = state_ff;
      query_in      = query_ff;
      lane_in       = lane_ff;
      base_in       = base_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      wcnt_in       = wcnt_ff;
      bvalid_in     = bvalid_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      tgt_we        = 1'b0;
      tgt_addr      = {probe_idx, wcnt_ff};
      bkt_we        = 1'b0;
      bkt_addr      = query_ff[0][63:56];

      case (state_ff)
         bsdm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  bsdm_pkg::CMD_TARGET: begin
                     tgt_addr = {req_data.entry_index, req_data.word_index};
                     tgt_we   = ({1'b0, req_data.entry_index} <
                                 (bsdm_pkg::IDX_W+1)'(bsdm_pkg::MAX_TARGETS)) &&
                                ({1'b0, req_data.word_index} < 3'(bsdm_pkg::WORDS));
                  end
                  bsdm_pkg::CMD_BUCKET: begin
                     bkt_we                       = 1'b1;
                     bkt_addr                     = req_data.bucket_id;
                     bvalid_in[req_data.bucket_id] = 1'b1;
                  end
                  bsdm_pkg::CMD_QUERY: begin
                     query_in[req_data.word_index] = req_data.word_value;
                     if (req_data.last_word) begin
                        lane_in  = req_data.lane_tag;
                        state_in = bsdm_pkg::ST_BUCKET;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bsdm_pkg::ST_BUCKET: begin
            state_in = bsdm_pkg::ST_RANGE;
         end
         bsdm_pkg::ST_RANGE: begin
            base_in = bbase;
            lo_in   = '0;
            hi_in   = bsdm_pkg::IDX_W'(size_eff - (bsdm_pkg::IDX_W+2)'(1));
            if (size_eff == '0) begin
               rsp_strobe_in = 1'b1;
               state_in      = bsdm_pkg::ST_IDLE;
            end else begin
               state_in = bsdm_pkg::ST_PROBE;
            end
         end
         bsdm_pkg::ST_PROBE: begin
            mid_in   = bsdm_pkg::IDX_W'(mid_sum >> 1);
            wcnt_in  = '0;
            tgt_addr = {base_ff + mid_in, 2'd0};
            if (lo_ff > {1'b0, hi_ff}) begin
               rsp_strobe_in = 1'b1;
               state_in      = bsdm_pkg::ST_IDLE;
            end else begin
               state_in = bsdm_pkg::ST_CMP;
            end
         end
         bsdm_pkg::ST_CMP: begin
            if (s_word < q_word) begin
               lo_in    = (bsdm_pkg::IDX_W+1)'(mid_ff) + (bsdm_pkg::IDX_W+1)'(1);
               state_in = bsdm_pkg::ST_PROBE;
            end else if (s_word > q_word) begin
               if (mid_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  state_in      = bsdm_pkg::ST_IDLE;
               end else begin
                  hi_in    = mid_ff - bsdm_pkg::IDX_W'(1);
                  state_in = bsdm_pkg::ST_PROBE;
               end
            end else if (wcnt_ff == last_w) begin
               rsp_strobe_in = 1'b1;
               state_in      = bsdm_pkg::ST_IDLE;
            end else begin
               wcnt_in  = wcnt_ff + 2'd1;
               tgt_addr = {probe_idx, wcnt_in};
            end
         end
         default: begin
            state_in = bsdm_pkg::ST_IDLE;
         end
      endcase

      // result build and query clear at the end of a search
      if (rsp_strobe_in) begin
         rsp_in.found        = (state_ff == bsdm_pkg::ST_CMP) && (s_word == q_word);
         rsp_in.target_index = rsp_in.found ? probe_idx : '0;
         rsp_in.lane_tag_out = lane_ff;
         if (rsp_in.found && (cnt_ff != '1)) begin
            cnt_in = cnt_ff + 32'd1;
         end
         rsp_in.match_total = cnt_in;
         for (int i = 0; i < bsdm_pkg::QWORDS; i++) query_in[i] = '0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `BSDM_ASSERT_NOW(a_miss_index_zero, rsp_strobe && !rsp_data.found, rsp_data.target_index == '0, "miss carries a nonzero index")
   `BSDM_ASSERT_NOW(a_rsp_from_search, rsp_strobe, $past(state_ff) != bsdm_pkg::ST_IDLE && $past(state_ff) != bsdm_pkg::ST_BUCKET, "result without a search")
   `BSDM_ASSERT_NEXT(a_count_on_hit, !(rsp_strobe_in && rsp_in.found), cnt_ff == $past(cnt_ff), "match count moved without a hit")
   `BSDM_ASSERT_NOW(a_idle_on_rsp, rsp_strobe, !busy, "busy while result is shown")

endmodule

// File: bench/tb_bucketed_sorted_digest_match.sv
// self-checking testbench for the bucketed sorted digest matcher: loads sorted target runs,
// then sends directed and random requests across several digest lengths and checks every answer
// depends on bsdm_pkg and bucketed_sorted_digest_match
module tb_bucketed_sorted_digest_match;
   import bsdm_pkg::*;

   localparam int         HALF_PERIOD    = 10;
   localparam int         TIMEOUT_CYCLES = 1200000;
   localparam int         SETTLE_CYCLES  = 80;
   localparam int         IDLE_PERCENT   = 14;
   localparam int         RUNS           = 16;
   localparam int         RUN_LEN        = 4;
   localparam int         LOW_REGION     = RUNS * RUN_LEN;
   localparam int         TOP_BASE       = MAX_TARGETS - 32;
   localparam int         PHASE_ITEMS    = 120;
   localparam int         PHASES         = 10;
   localparam int         MAX_REPORTS    = 40;
   localparam logic [7:0] TOP_FIRST      = 8'h8F;
   localparam logic [7:0] EMPTY_FIRST    = 8'h0F;
   localparam logic [1:0] CMD_NONE       = 2'd3;

   typedef enum int {Q_FULL, Q_SHORT, Q_SCRAMBLED, Q_ONE_WORD} query_shape_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [5:0] csr_wdata = '0;

   // predicted state of the block
   logic [63:0] target_words [0:TGT_DEPTH-1];
   logic [11:0] bucket_base_tab [0:BKT_DEPTH-1];
   logic [12:0] bucket_size_tab [0:BKT_DEPTH-1];
   logic [63:0] query_buf [0:QWORDS-1];
   logic [31:0] matches_seen;
   logic [5:0]  digest_len_reg;

   rsp_type     expected_answers [$];
   req_type     pending_requests [$];
   int unsigned mismatch_count = 0;
   int unsigned requests_taken = 0;

   // stimulus bookkeeping
   logic [255:0] shadow_digest [0:MAX_TARGETS-1];
   logic [7:0]   run_first [0:RUNS-1];
   logic [5:0]   len_plan [0:PHASES-1];
   int           live_len;
   int unsigned  queued_items = 0;

   bucketed_sorted_digest_match u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // -1 when the stored entry sorts below the query, 0 equal, 1 above
   function automatic int compare_target(input int entry, input int nbytes);
      int         order;
      logic [7:0] s;
      logic [7:0] q;
      order = 0;
      for (int b = 0; b < nbytes && order == 0; b++) begin
         s = target_words[entry * WORDS + b / 8][63 - 8 * (b % 8) -: 8];
         q = query_buf[b / 8][63 - 8 * (b % 8) -: 8];
         if (s < q) order = -1;
         else if (s > q) order = 1;
      end
      return order;
   endfunction

   function automatic rsp_type search_digest(input logic [3:0] tag);
      int         nbytes;
      int         base;
      int         run;
      int         lo;
      int         hi;
      int         mid;
      int         order;
      logic [7:0] first;
      logic       hit;
      logic       done;
      rsp_type    ans;
      nbytes = (digest_len_reg == 0) ? 1 :
               (digest_len_reg > MAX_DIGEST_BYTES) ? MAX_DIGEST_BYTES : int'(digest_len_reg);
      first = query_buf[0][63:56];
      base = int'(bucket_base_tab[first]);
      run = int'(bucket_size_tab[first]);
      if (run > MAX_TARGETS - base) run = MAX_TARGETS - base;
      ans = '0;
      hit = 1'b0;
      done = (run == 0);
      lo = 0;
      hi = run - 1;
      while (!done && lo <= hi) begin
         mid = (lo + hi) / 2;
         order = compare_target(base + mid, nbytes);
         if (order == 0) begin
            hit = 1'b1;
            ans.target_index = 12'(base + mid);
            done = 1'b1;
         end else if (order < 0) begin
            lo = mid + 1;
         end else if (mid == 0) begin
            done = 1'b1;
         end else begin
            hi = mid - 1;
         end
      end
      if (hit && matches_seen != '1) matches_seen++;
      ans.found = hit;
      ans.lane_tag_out = tag;
      ans.match_total = matches_seen;
      return ans;
   endfunction

   function automatic void apply_request(input req_type r);
      case (r.command)
         CMD_TARGET: target_words[r.entry_index * WORDS + r.word_index] = r.word_value;
         CMD_BUCKET: begin
            bucket_base_tab[r.bucket_id] = r.bucket_base;
            bucket_size_tab[r.bucket_id] = r.bucket_size;
         end
         CMD_QUERY: begin
            query_buf[r.word_index] = r.word_value;
            if (r.last_word) begin
               expected_answers.push_back(search_digest(r.lane_tag));
               foreach (query_buf[i]) query_buf[i] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [255:0] random_digest();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic req_type noise_req();
      req_type r;
      r = req_type'($bits(req_type)'({$urandom, $urandom, $urandom, $urandom}));
      return r;
   endfunction

   function automatic void push_word(input int entry, input int w, input logic [63:0] value);
      req_type r;
      r = noise_req();
      r.command = CMD_TARGET;
      r.entry_index = 12'(entry);
      r.word_index = 2'(w);
      r.word_value = value;
      pending_requests.push_back(r);
      shadow_digest[entry][255 - 64 * w -: 64] = value;
      queued_items++;
   endfunction

   function automatic void push_digest(input int entry, input logic [255:0] dg);
      for (int w = 0; w < WORDS; w++) push_word(entry, w, dg[255 - 64 * w -: 64]);
   endfunction

   function automatic void push_bucket(input logic [7:0] id, input int base, input int size);
      req_type r;
      r = noise_req();
      r.command = CMD_BUCKET;
      r.bucket_id = id;
      r.bucket_base = 12'(base);
      r.bucket_size = 13'(size);
      pending_requests.push_back(r);
      queued_items++;
   endfunction

   function automatic void push_loose_word(input int w, input logic [63:0] value);
      req_type r;
      r = noise_req();
      r.command = CMD_QUERY;
      r.word_index = 2'(w);
      r.word_value = value;
      r.last_word = 1'b0;
      pending_requests.push_back(r);
      queued_items++;
   endfunction

   function automatic void push_ignored();
      req_type r;
      r = noise_req();
      r.command = cmd_type'(CMD_NONE);
      pending_requests.push_back(r);
   endfunction

   function automatic void push_query(input logic [255:0] dg, input logic [3:0] tag,
                                      input query_shape_type shape);
      req_type r;
      int      nw;
      int      w;
      case (shape)
         Q_SHORT: nw = (live_len + 7) / 8;
         Q_SCRAMBLED: nw = $urandom_range(QWORDS, 1);
         Q_ONE_WORD: nw = 1;
         default: nw = QWORDS;
      endcase
      for (int k = 0; k < nw; k++) begin
         w = (shape == Q_SCRAMBLED) ? $urandom_range(QWORDS - 1) : k;
         r = noise_req();
         r.command = CMD_QUERY;
         r.word_index = 2'(w);
         r.word_value = dg[255 - 64 * w -: 64];
         r.lane_tag = tag;
         r.last_word = (k == nw - 1);
         pending_requests.push_back(r);
         queued_items++;
      end
   endfunction

   // mostly stored digests, then near misses, bucket misses and arbitrary digests
   function automatic logic [255:0] pick_digest();
      logic [255:0] dg;
      int           kind;
      int           b;
      kind = $urandom_range(99);
      if ($urandom_range(4) == 0) dg = shadow_digest[TOP_BASE + $urandom_range(31)];
      else dg = shadow_digest[$urandom_range(LOW_REGION - 1)];
      if (kind >= 55 && kind < 75) begin
         b = $urandom_range(live_len - 1);
         dg[255 - 8 * b -: 8] = dg[255 - 8 * b -: 8] ^ 8'($urandom_range(255, 1));
      end else if (kind >= 75 && kind < 90) begin
         dg = random_digest();
         dg[255:248] = run_first[$urandom_range(RUNS - 1)];
      end else if (kind >= 90) begin
         dg = random_digest();
      end
      if ($urandom_range(9) < 7) dg = dg & ~({256{1'b1}} >> (8 * live_len));
      return dg;
   endfunction

   function automatic void queue_random_mix(input int count);
      int unsigned     goal;
      int              pick;
      int              k;
      int              base;
      query_shape_type shape;
      goal = queued_items + count;
      while (queued_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            if ($urandom_range(9) == 0)
               push_word($urandom_range(LOW_REGION - 1), $urandom_range(WORDS - 1),
                         {$urandom, $urandom});
            else
               push_word($urandom_range(TOP_BASE - 1, LOW_REGION), $urandom_range(WORDS - 1),
                         {$urandom, $urandom});
         end else if (pick < 18) begin
            k = $urandom_range(RUNS - 1);
            base = $urandom_range(LOW_REGION - 1);
            case ($urandom_range(4))
               0: push_bucket(8'($urandom), $urandom_range(MAX_TARGETS - 1), 0);
               1: push_bucket(8'($urandom), base, $urandom_range(LOW_REGION - base, 1));
               2: push_bucket(8'($urandom), TOP_BASE + $urandom_range(31),
                              $urandom_range(MAX_TARGETS));
               3: push_bucket(TOP_FIRST, TOP_BASE, $urandom_range(MAX_TARGETS, 1));
               default: push_bucket(run_first[k], k * RUN_LEN, RUN_LEN);
            endcase
         end else if (pick < 21) begin
            push_ignored();
         end else if (pick < 24) begin
            push_loose_word($urandom_range(QWORDS - 1), {$urandom, $urandom});
         end else begin
            k = $urandom_range(99);
            shape = (k < 70) ? Q_FULL : (k < 88) ? Q_SHORT : (k < 95) ? Q_SCRAMBLED : Q_ONE_WORD;
            push_query(pick_digest(), 4'($urandom), shape);
         end
      end
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_requests.size() != 0 || start || expected_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(req_data);
            requests_taken++;
         end
         if (!start || !busy) begin
            if (pending_requests.size() > 0 &&
                ((requests_taken % 700) < 200 || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_data <= pending_requests.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_data), '0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch("found", 64'(rsp_data.found), 64'(want.found));
            if (rsp_data.target_index !== want.target_index)
               report_mismatch("target_index", 64'(rsp_data.target_index),
                               64'(want.target_index));
            if (rsp_data.lane_tag_out !== want.lane_tag_out)
               report_mismatch("lane_tag_out", 64'(rsp_data.lane_tag_out),
                               64'(want.lane_tag_out));
            if (rsp_data.match_total !== want.match_total)
               report_mismatch("match_total", 64'(rsp_data.match_total),
                               64'(want.match_total));
         end
      end
   end

   initial begin
      logic [255:0] dg;
      foreach (bucket_base_tab[i]) bucket_base_tab[i] = '0;
      foreach (bucket_size_tab[i]) bucket_size_tab[i] = '0;
      foreach (query_buf[i]) query_buf[i] = '0;
      matches_seen = '0;
      digest_len_reg = 6'(MAX_DIGEST_BYTES);
      live_len = MAX_DIGEST_BYTES;
      len_plan = '{6'd20, 6'd16, 6'd0, 6'd1, 6'd63, 6'd8, 6'd33, 6'd32, 6'd9, 6'($urandom)};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // sorted runs: low region by bucket, top region behind an oversize bucket
      run_first[0] = 8'h00;
      run_first[RUNS - 1] = 8'hFF;
      for (int k = 1; k < RUNS - 1; k++) run_first[k] = 8'(k * 16 + $urandom_range(14));
      for (int k = 0; k < RUNS; k++) begin
         for (int p = 0; p < RUN_LEN; p++) begin
            dg = random_digest();
            dg[255:248] = run_first[k];
            dg[247:240] = 8'(p * 64 + $urandom_range(63));
            push_digest(k * RUN_LEN + p, dg);
         end
      end
      for (int p = 0; p < MAX_TARGETS - TOP_BASE; p++) begin
         dg = random_digest();
         dg[255:248] = TOP_FIRST;
         dg[247:240] = 8'(p * 8 + $urandom_range(7));
         push_digest(TOP_BASE + p, dg);
      end
      for (int k = 0; k < RUNS; k++) push_bucket(run_first[k], k * RUN_LEN, RUN_LEN);
      push_bucket(TOP_FIRST, TOP_BASE, MAX_TARGETS);

      // directed: edge entries, clipped bucket, empty bucket, underflow, ignored command
      push_query(shadow_digest[0], 4'h0, Q_FULL);
      push_query(shadow_digest[LOW_REGION - 1], 4'hF, Q_FULL);
      push_bucket(TOP_FIRST, MAX_TARGETS - 1, MAX_TARGETS);
      push_query(shadow_digest[MAX_TARGETS - 1], 4'h5, Q_FULL);
      push_bucket(TOP_FIRST, TOP_BASE, MAX_TARGETS);
      push_bucket(EMPTY_FIRST, MAX_TARGETS - 1, 0);
      push_query({EMPTY_FIRST, 248'(0)}, 4'hA, Q_ONE_WORD);
      push_query({256{1'b1}}, 4'h3, Q_ONE_WORD);
      push_query({run_first[RUNS - 1], 248'(0)}, 4'hC, Q_ONE_WORD);
      push_ignored();
      push_loose_word(1, shadow_digest[21][191:128]);
      push_ignored();
      push_query(shadow_digest[21], 4'h9, Q_FULL);

      queue_random_mix(PHASE_ITEMS);
      for (int i = 0; i < PHASES; i++) begin
         wait_drained();
         @(posedge clock);
         csr_we <= 1'b1;
         csr_wdata <= len_plan[i];
         digest_len_reg = len_plan[i];
         live_len = (len_plan[i] == 0) ? 1 :
                    (len_plan[i] > MAX_DIGEST_BYTES) ? MAX_DIGEST_BYTES : int'(len_plan[i]);
         @(posedge clock);
         csr_we <= 1'b0;
         @(posedge clock);
         queue_random_mix(PHASE_ITEMS);
      end
      wait_drained();

      if (mismatch_count == 0) begin
         $display("[bucketed_sorted_digest_match] OK");
      end else begin
         $display("[bucketed_sorted_digest_match] ERROR");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
      $display("[bucketed_sorted_digest_match] ERROR");
      $finish;
   end

endmodule
